// ----- src/pbvc_pkg.sv -----
// Shared types, constants and functions of the packet bit vote combiner.
// Used by the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pbvc_pkg;

   localparam int MAX_BYTES     = 255;
   localparam int MAX_BITS      = 2040;
   localparam int COUNTER_WIDTH = 8;

   localparam int BYTE_LIMIT = (MAX_BYTES < MAX_BITS / 8) ? MAX_BYTES : MAX_BITS / 8;
   localparam int ROW_WIDTH  = 8 * COUNTER_WIDTH;
   localparam int ADDR_WIDTH = $clog2(BYTE_LIMIT);

   localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNTER_WIDTH-1){1'b1}}};
   localparam logic [COUNTER_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNTER_WIDTH-1){1'b0}}};

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [7:0] SLOT_RESET  = 8'd0;
   localparam logic [7:0] EPOCH_RESET = 8'd4;
   localparam logic [7:0] MIN_RESET   = 8'd3;

   localparam logic [1:0] CSR_SLOT  = 2'd0;
   localparam logic [1:0] CSR_EPOCH = 2'd1;
   localparam logic [1:0] CSR_MIN   = 2'd2;

   typedef enum logic [1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_VOTE    = 2'd1,
      CMD_RESOLVE = 2'd2,
      CMD_READ    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_ACK      = 2'd0,
      ST_MATCH    = 2'd1,
      ST_MISMATCH = 2'd2,
      ST_SKIPPED  = 2'd3
   } status_type;

   function automatic logic in_range(input logic [7:0] idx);
      in_range = ({1'b0, idx} < 9'(BYTE_LIMIT));
   endfunction

   function automatic logic is_masked(input logic [7:0] idx, input logic [7:0] slot,
                                      input logic [7:0] epoch);
      is_masked = (idx == slot) || (idx == epoch) ||
                  ({1'b0, idx} == ({1'b0, epoch} + 9'd1));
   endfunction

   function automatic logic [7:0] decide_byte(input logic [ROW_WIDTH-1:0] row);
      logic [7:0] v;
      for (int b = 0; b < 8; b++) begin
         v[b] = ~row[b*COUNTER_WIDTH + COUNTER_WIDTH - 1];
      end
      decide_byte = v;
   endfunction

   function automatic logic [ROW_WIDTH-1:0] vote_row(input logic [ROW_WIDTH-1:0] row,
                                                     input logic [7:0] data);
      logic [ROW_WIDTH-1:0]     r;
      logic [COUNTER_WIDTH-1:0] c;
      r = row;
      for (int b = 0; b < 8; b++) begin
         c = row[b*COUNTER_WIDTH +: COUNTER_WIDTH];
         if (data[b]) begin
            if (c != CNT_MAX) c = c + COUNTER_WIDTH'(1);
         end else begin
            if (c != CNT_MIN) c = c - COUNTER_WIDTH'(1);
         end
         r[b*COUNTER_WIDTH +: COUNTER_WIDTH] = c;
      end
      vote_row = r;
   endfunction

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
         else       c = {c[14:0], 1'b0};
      end
      crc_step = c;
   endfunction

endpackage

`default_nettype wire

// ----- src/pbvc_ram.sv -----
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pbvc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- src/packet_bit_vote_combiner.sv -----
// Top level of the packet bit vote combiner: command sequencer and vote memory.
// Depends on pbvc_pkg and pbvc_ram.
//
// Usage: items enter on req_* (valid/stall), one result item per item leaves on
// rsp_* (valid/stall). csr_* writes slot offset, epoch offset and minimum copies
// (index 0..2); csr_ready is always high, write only while the block is idle.
// Vote counters sit in a 255-row memory, one row of eight counters per byte.
// Each row has a valid bit cleared at once by reset or clear, so an unwritten
// row reads as zero counters; there is no clearing pass.
// Clear, skipped or repeated resolve and ignored votes pass from the accepting
// edge straight to the emit state; vote and read first pass their own state
// (for a vote: memory read, then modify and write back). A full resolve reads
// one row per cycle through the single read port, folds each byte before the
// two-byte trailer into the CRC (masked bytes as zero) and compares the CRC
// with the trailer. One item is in work at a time; req_stall is low only when
// idle, and a new item may be accepted while the previous result waits.
// While rsp_stall is high the result holds and the block waits before loading
// the next one. Reset restores register defaults and empties all votes.
`timescale 1ns / 1ps
`default_nettype none

module packet_bit_vote_combiner
   import pbvc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_command,
   input  wire logic [7:0] req_byte_index,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   input  wire logic       req_good_copy_seen,

   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_voted_byte,
   output logic [1:0]      rsp_status,
   output logic [7:0]      rsp_copy_count,

   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_VOTE,
      S_READ,
      S_WALK,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic [7:0] slot_ff, epoch_ff, min_ff;

   logic [7:0] copies_ff, copies_in;
   logic [7:0] len_ff, len_in;
   logic       ok_ff, ok_in;
   logic [BYTE_LIMIT-1:0] row_valid_ff, row_valid_in;

   logic [7:0] op_idx_ff, op_idx_in;
   logic [7:0] op_data_ff, op_data_in;
   logic       op_last_ff, op_last_in;

   logic [7:0]  iss_ff, iss_in;
   logic        pend_ff, pend_in;
   logic [7:0]  rd_idx_ff, rd_idx_in;
   logic        rvalid_ff, rvalid_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  lo_ff, lo_in;

   status_type  res_status_ff, res_status_in;
   logic [7:0]  res_voted_ff, res_voted_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_voted_ff, rsp_voted_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [7:0] rsp_copy_ff, rsp_copy_in;

   logic                  ram_we;
   logic [ADDR_WIDTH-1:0] ram_waddr;
   logic [ROW_WIDTH-1:0]  ram_wdata;
   logic [ADDR_WIDTH-1:0] ram_raddr;
   logic [ROW_WIDTH-1:0]  ram_rdata;

   logic                  req_accept;
   logic                  out_free;
   logic [ROW_WIDTH-1:0]  row_cur;
   logic [7:0]            byte_cur;
   logic [15:0]           trailer;
   cmd_type               cmd;

   assign cmd        = cmd_type'(req_command);
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   assign row_cur  = rvalid_ff ? ram_rdata : '0;
   assign byte_cur = decide_byte(row_cur);
   assign trailer  = {byte_cur, lo_ff};

   assign ram_waddr = op_idx_ff[ADDR_WIDTH-1:0];
   assign ram_wdata = vote_row(row_cur, op_data_ff);
   assign ram_raddr = (state_ff == S_WALK) ? iss_ff[ADDR_WIDTH-1:0]
                                           : req_byte_index[ADDR_WIDTH-1:0];

   pbvc_ram #(
      .WIDTH(ROW_WIDTH),
      .DEPTH(BYTE_LIMIT)
   ) u_votes (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      copies_in     = copies_ff;
      len_in        = len_ff;
      ok_in         = ok_ff;
      row_valid_in  = row_valid_ff;
      op_idx_in     = op_idx_ff;
      op_data_in    = op_data_ff;
      op_last_in    = op_last_ff;
      iss_in        = iss_ff;
      pend_in       = 1'b0;
      rd_idx_in     = iss_ff;
      crc_in        = crc_ff;
      lo_in         = lo_ff;
      res_status_in = res_status_ff;
      res_voted_in  = res_voted_ff;
      rsp_voted_in  = rsp_voted_ff;
      rsp_status_in = rsp_status_ff;
      rsp_copy_in   = rsp_copy_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ram_we        = 1'b0;
      rvalid_in     = in_range(8'(ram_raddr)) ? row_valid_ff[ram_raddr] : 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_idx_in     = req_byte_index;
               op_last_in    = req_last_byte;
               op_data_in    = is_masked(req_byte_index, slot_ff, epoch_ff) ?
                               8'h00 : req_data_byte;
               res_status_in = ST_ACK;
               res_voted_in  = 8'h00;
               unique case (cmd)
                  CMD_CLEAR: begin
                     row_valid_in = '0;
                     copies_in    = 8'd0;
                     len_in       = 8'd0;
                     ok_in        = 1'b0;
                     state_in     = S_EMIT;
                  end
                  CMD_VOTE: begin
                     state_in = (!ok_ff && in_range(req_byte_index)) ? S_VOTE : S_EMIT;
                  end
                  CMD_RESOLVE: begin
                     priority if (ok_ff) begin
                        res_status_in = ST_MATCH;
                        state_in      = S_EMIT;
                     end else if (req_good_copy_seen || copies_ff < min_ff ||
                                  len_ff < 8'd2) begin
                        res_status_in = ST_SKIPPED;
                        state_in      = S_EMIT;
                     end else begin
                        iss_in   = 8'd0;
                        crc_in   = CRC_INIT;
                        state_in = S_WALK;
                     end
                  end
                  CMD_READ: begin
                     state_in = S_READ;
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_VOTE: begin
            ram_we                        = 1'b1;
            row_valid_in[ram_waddr]       = 1'b1;
            if (op_last_ff) begin
               len_in = op_idx_ff + 8'd1;
               if (copies_ff != 8'hFF) copies_in = copies_ff + 8'd1;
            end
            state_in = S_EMIT;
         end
         S_READ: begin
            res_voted_in = in_range(op_idx_ff) ? byte_cur : 8'h00;
            state_in     = S_EMIT;
         end
         S_WALK: begin
            if (iss_ff < len_ff) begin
               pend_in = 1'b1;
               iss_in  = iss_ff + 8'd1;
            end
            if (pend_ff) begin
               priority if (({1'b0, rd_idx_ff} + 9'd2) < {1'b0, len_ff}) begin
                  crc_in = crc_step(crc_ff, is_masked(rd_idx_ff, slot_ff, epoch_ff) ?
                                    8'h00 : byte_cur);
               end else if (({1'b0, rd_idx_ff} + 9'd1) < {1'b0, len_ff}) begin
                  lo_in = byte_cur;
               end else begin
                  pend_in = 1'b0;
                  if (crc_ff == trailer) begin
                     ok_in         = 1'b1;
                     res_status_in = ST_MATCH;
                  end else begin
                     res_status_in = ST_MISMATCH;
                  end
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_voted_in  = res_voted_ff;
               rsp_status_in = res_status_ff;
               rsp_copy_in   = copies_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         copies_ff    <= 8'd0;
         len_ff       <= 8'd0;
         ok_ff        <= 1'b0;
         row_valid_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         slot_ff      <= SLOT_RESET;
         epoch_ff     <= EPOCH_RESET;
         min_ff       <= MIN_RESET;
      end else begin
         state_ff     <= state_in;
         copies_ff    <= copies_in;
         len_ff       <= len_in;
         ok_ff        <= ok_in;
         row_valid_ff <= row_valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SLOT:  slot_ff  <= csr_wdata;
               CSR_EPOCH: epoch_ff <= csr_wdata;
               CSR_MIN:   min_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      op_idx_ff     <= op_idx_in;
      op_data_ff    <= op_data_in;
      op_last_ff    <= op_last_in;
      iss_ff        <= iss_in;
      rd_idx_ff     <= rd_idx_in;
      rvalid_ff     <= rvalid_in;
      crc_ff        <= crc_in;
      lo_ff         <= lo_in;
      res_status_ff <= res_status_in;
      res_voted_ff  <= res_voted_in;
      rsp_voted_ff  <= rsp_voted_in;
      rsp_status_ff <= rsp_status_in;
      rsp_copy_ff   <= rsp_copy_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_voted_byte = rsp_voted_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_copy_count = rsp_copy_ff;

`ifndef SYNTHESIS
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ({1'b0, op_idx_ff} < 9'(BYTE_LIMIT)))
      else $error("vote memory written beyond the byte limit");

   a_copies_drop_on_clear: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (copies_ff < $past(copies_ff))) |->
      $past(req_accept && (req_command == CMD_CLEAR)))
      else $error("copy count fell without a clear item");

   a_ok_from_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(ok_ff) |-> $past(state_ff == S_WALK))
      else $error("success latched outside a resolve walk");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result raised outside the emit state");
`endif

endmodule

`default_nettype wire
